/* design/aidp_pkg.sv */
// Shared constants, command and status types for the array insert/delete unit.
package aidp_pkg;

  localparam int CAPACITY  = 32;
  localparam int WORD_BITS = 32;

  // Width that holds an entry count from zero up to CAPACITY.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Width that addresses one entry.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // Width for comparing a position against the count without overflow.
  localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] ST_ELEMENT    = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_INSERT = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_DELETE = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd4;

  // Kind of result the controller asks the datapath to register.
  localparam logic [1:0] KIND_ELEM  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic       load;
    logic       apply;
    logic       idx_clr;
    logic       idx_inc;
    logic       out_load;
    logic [1:0] out_kind;
  } aidp_cmd_t;

  typedef struct packed {
    logic op_err;
    logic out_free;
    logic count_zero;
    logic idx_last;
  } aidp_stat_t;

  // Stored word: low WORD_BITS bits of the sign-extended input.
  function automatic word_t to_word(input logic signed [DATA_W-1:0] v);
    return WORD_BITS'(v);
  endfunction

  // Output element: stored word sign-extended, then cut to the field width.
  function automatic logic signed [DATA_W-1:0] to_elem(input word_t w);
    return DATA_W'(signed'(w));
  endfunction

endpackage

/* design/aidp_if.sv */
// Handshake interfaces for the input and result channels.
interface aidp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic [aidp_pkg::POS_W-1:0]           position;
  logic signed [aidp_pkg::DATA_W-1:0]   value;

  modport source (output valid, op, position, value, input ready);
  modport sink   (input valid, op, position, value, output ready);
endinterface

interface aidp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [aidp_pkg::STAT_W-1:0]          status;
  logic signed [aidp_pkg::DATA_W-1:0]   element;
  logic                                 last;

  modport source (output valid, status, element, last, input ready);
  modport sink   (input valid, status, element, last, output ready);
endinterface

/* design/aidp_ctrl.sv */
// Controller state machine: accepts an item, applies it and sequences the results.
module aidp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aidp_pkg::aidp_stat_t  stat,
  output aidp_pkg::aidp_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.out_kind = aidp_pkg::KIND_ELEM;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op_err) begin
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = aidp_pkg::KIND_ERROR;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.apply   = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.count_zero) begin
            cmd.out_kind = aidp_pkg::KIND_EMPTY;
            state_nxt    = S_IDLE;
          end else begin
            cmd.out_kind = aidp_pkg::KIND_ELEM;
            cmd.idx_inc  = 1'b1;
            if (stat.idx_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* design/aidp_dp.sv */
// Datapath: entry registers, count, position checks and the output register.
module aidp_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  aidp_pkg::aidp_cmd_t                 cmd,
  output aidp_pkg::aidp_stat_t                stat,
  input  logic                                in_op,
  input  logic [aidp_pkg::POS_W-1:0]          in_position,
  input  logic signed [aidp_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [aidp_pkg::STAT_W-1:0]         out_status,
  output logic signed [aidp_pkg::DATA_W-1:0]  out_element,
  output logic                                out_last
);

  aidp_pkg::word_t                    entries_r [aidp_pkg::CAPACITY];
  logic [aidp_pkg::CNT_W-1:0]         count_r;
  logic [aidp_pkg::CNT_W-1:0]         rd_idx_r;
  logic                               op_r;
  logic [aidp_pkg::POS_W-1:0]         pos_r;
  aidp_pkg::word_t                    word_r;

  logic                               out_valid_r;
  logic [aidp_pkg::STAT_W-1:0]        out_status_r;
  logic signed [aidp_pkg::DATA_W-1:0] out_element_r;
  logic                               out_last_r;

  logic [aidp_pkg::CMP_W-1:0]         pos_w, cnt_w, pos_m1;
  logic                               bad_ins, bad_del, is_full;
  logic [aidp_pkg::STAT_W-1:0]        err_code;
  logic                               idx_last;

  always_comb begin
    pos_w   = aidp_pkg::CMP_W'(pos_r);
    cnt_w   = aidp_pkg::CMP_W'(count_r);
    pos_m1  = pos_w - aidp_pkg::CMP_W'(1);
    bad_ins = (pos_w == '0) || (pos_w > cnt_w + aidp_pkg::CMP_W'(1));
    bad_del = (pos_w == '0) || (pos_w > cnt_w);
    is_full = (cnt_w == aidp_pkg::CMP_W'(aidp_pkg::CAPACITY));
    if (op_r == aidp_pkg::OP_INSERT) begin
      err_code = bad_ins ? aidp_pkg::ST_BAD_INSERT : aidp_pkg::ST_FULL;
    end else begin
      err_code = aidp_pkg::ST_BAD_DELETE;
    end
  end

  assign idx_last        = (rd_idx_r + aidp_pkg::CNT_W'(1) == count_r);
  assign stat.op_err     = (op_r == aidp_pkg::OP_INSERT) ? (bad_ins || is_full) : bad_del;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.count_zero = (count_r == '0);
  assign stat.idx_last   = idx_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      pos_r  <= in_position;
      word_r <= aidp_pkg::to_word(in_value);
    end
  end

  // Every entry picks its neighbor, the new word or itself on an apply command.
  for (genvar i = 0; i < aidp_pkg::CAPACITY; i++) begin : g_entry
    localparam logic [aidp_pkg::CMP_W-1:0] IPOS = aidp_pkg::CMP_W'(i);
    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        if (op_r == aidp_pkg::OP_INSERT) begin
          if (IPOS == pos_m1) begin
            entries_r[i] <= word_r;
          end else if (IPOS > pos_m1) begin
            entries_r[i] <= entries_r[(i > 0) ? i - 1 : 0];
          end
        end else if (IPOS >= pos_m1 && i < aidp_pkg::CAPACITY - 1) begin
          entries_r[i] <= entries_r[(i < aidp_pkg::CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.apply) begin
        if (op_r == aidp_pkg::OP_INSERT) begin
          count_r <= count_r + aidp_pkg::CNT_W'(1);
        end else begin
          count_r <= count_r - aidp_pkg::CNT_W'(1);
        end
      end
      if (cmd.idx_clr) begin
        rd_idx_r <= '0;
      end else if (cmd.idx_inc) begin
        rd_idx_r <= rd_idx_r + aidp_pkg::CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        aidp_pkg::KIND_ELEM: begin
          out_status_r  <= aidp_pkg::ST_ELEMENT;
          out_element_r <= aidp_pkg::to_elem(entries_r[rd_idx_r[aidp_pkg::IDX_W-1:0]]);
          out_last_r    <= idx_last;
        end
        aidp_pkg::KIND_EMPTY: begin
          out_status_r  <= aidp_pkg::ST_EMPTY;
          out_element_r <= '0;
          out_last_r    <= 1'b1;
        end
        default: begin
          out_status_r  <= err_code;
          out_element_r <= '0;
          out_last_r    <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

endmodule

/* design/array_insert_delete_at_position_unit.sv */
// Top level of the ordered-list unit with insert and delete at a 1-based position.
// An item is accepted, checked and the list shifted, then the results follow one per
// cycle while the output register is free: every entry in order for a successful
// operation, a single status for an error and one for an emptied list. A new item is
// accepted only after the last result of the one before it is registered.
// Reset (synchronous, active low) empties the list and drops any pending result.
module array_insert_delete_at_position_unit (
  input  logic       clk,
  input  logic       rst_n,
  aidp_in_if.sink    in_ch,
  aidp_out_if.source out_ch
);

  // Command and status bundles between the controller and the datapath.
  aidp_pkg::aidp_cmd_t  cmd;
  aidp_pkg::aidp_stat_t stat;

  // The controller owns the input handshake and decides, cycle by cycle,
  // which result the datapath registers next.
  aidp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the entries and count, checks the position, shifts the
  // list on an apply command and drives the output register.
  aidp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_ch.op),
    .in_position (in_ch.position),
    .in_value    (in_ch.value),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_element (out_ch.element),
    .out_last    (out_ch.last)
  );

endmodule

/* verif/array_insert_delete_at_position_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the ordered-list unit with insert and delete at a 1-based position.
module array_insert_delete_at_position_unit_tb;

  // One result as it leaves the block.
  typedef struct {
    logic [aidp_pkg::STAT_W-1:0]        status;
    logic signed [aidp_pkg::DATA_W-1:0] element;
    logic                               last;
  } list_result_t;

  // Tracks the list contents and the results each accepted command must produce.
  class list_tracker;
    aidp_pkg::word_t list_words[$];
    list_result_t    pending_results[$];
    int              errors;

    function int list_size();
      return list_words.size();
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 30) $display("mismatch: %s", msg);
    endtask

    function void push_single(logic [aidp_pkg::STAT_W-1:0] st);
      list_result_t r;
      r.status  = st;
      r.element = '0;
      r.last    = 1'b1;
      pending_results.push_back(r);
    endfunction

    function void push_whole_list();
      list_result_t r;
      foreach (list_words[i]) begin
        r.status  = aidp_pkg::ST_ELEMENT;
        r.element = aidp_pkg::DATA_W'(signed'(list_words[i]));
        r.last    = (i == list_words.size() - 1);
        pending_results.push_back(r);
      end
    endfunction

    // Applies one accepted command to the list copy and queues its results.
    function void note_command(logic op, logic [aidp_pkg::POS_W-1:0] pos,
                               logic signed [aidp_pkg::DATA_W-1:0] val);
      int cnt;
      cnt = list_words.size();
      if (op == aidp_pkg::OP_INSERT) begin
        if (pos < 1 || pos > cnt + 1) begin
          push_single(aidp_pkg::ST_BAD_INSERT);
        end else if (cnt >= aidp_pkg::CAPACITY) begin
          push_single(aidp_pkg::ST_FULL);
        end else begin
          list_words.insert(pos - 1, aidp_pkg::word_t'(val));
          push_whole_list();
        end
      end else begin
        if (pos < 1 || pos > cnt) begin
          push_single(aidp_pkg::ST_BAD_DELETE);
        end else begin
          list_words.delete(pos - 1);
          if (list_words.size() == 0) push_single(aidp_pkg::ST_EMPTY);
          else push_whole_list();
        end
      end
    endfunction

    task check_result(logic [aidp_pkg::STAT_W-1:0] st,
                      logic signed [aidp_pkg::DATA_W-1:0] el, logic lst);
      list_result_t exp_r;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d element %0d last %0d",
                                  st, el, lst));
      end else begin
        exp_r = pending_results.pop_front();
        if (st !== exp_r.status)
          report_mismatch($sformatf("status %0d, wanted %0d", st, exp_r.status));
        if (el !== exp_r.element)
          report_mismatch($sformatf("element %0d, wanted %0d", el, exp_r.element));
        if (lst !== exp_r.last)
          report_mismatch($sformatf("last %0d, wanted %0d", lst, exp_r.last));
      end
    endtask
  endclass

  localparam int ITEM_GOAL   = 380;
  localparam int CYCLE_LIMIT = 400000;
  // A full list yields CAPACITY results per command; allow a margin on top.
  localparam int DRAIN_CYCLES = aidp_pkg::CAPACITY + 20;

  logic clk;
  logic rst_n;
  int   cycles;
  bit   idle_on;
  int   sent;

  aidp_in_if  in_ch();
  aidp_out_if out_ch();

  list_tracker sb = new();

  array_insert_delete_at_position_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[array_insert_delete_at_position_unit] ERROR");
      $finish;
    end
  end

  // Every accepted result is checked against the oldest pending one.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.element, out_ch.last);
  end

  // Result side: ready drops in short random bursts while idling is enabled.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        stall_left   = $urandom_range(1, 4) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Presents one command, with an optional idle gap first, and waits until it is accepted.
  // The list copy is updated at the accepting edge, so the next command sees the new count.
  task send_item(logic op, logic [aidp_pkg::POS_W-1:0] pos,
                 logic signed [aidp_pkg::DATA_W-1:0] val);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.op       = op;
    in_ch.position = pos;
    in_ch.value    = val;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(op, pos, val);
    sent++;
  endtask

  // Values lean on the extremes now and then; the rest are fully random words.
  function logic signed [aidp_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // Builds one random command. Most are well formed against the current count, with
  // the list ends favored; a share are noise with any position at all.
  task send_random(int insert_pct, int noise_pct);
    logic                       op;
    logic [aidp_pkg::POS_W-1:0] pos;
    int                         cnt;
    cnt = sb.list_size();
    op  = ($urandom_range(0, 99) < insert_pct) ? aidp_pkg::OP_INSERT : aidp_pkg::OP_DELETE;
    if ($urandom_range(0, 99) < noise_pct) begin
      pos = aidp_pkg::POS_W'($urandom_range(0, 63));
    end else if (op == aidp_pkg::OP_INSERT) begin
      case ($urandom_range(0, 3))
        0: pos = 6'd1;
        1: pos = aidp_pkg::POS_W'(cnt + 1);
        default: pos = aidp_pkg::POS_W'($urandom_range(1, cnt + 1));
      endcase
    end else if (cnt == 0) begin
      pos = aidp_pkg::POS_W'($urandom_range(0, 63));
    end else begin
      case ($urandom_range(0, 3))
        0: pos = 6'd1;
        1: pos = aidp_pkg::POS_W'(cnt);
        default: pos = aidp_pkg::POS_W'($urandom_range(1, cnt));
      endcase
    end
    send_item(op, pos, pick_value());
  endtask

  initial begin
    int ep_len;
    int ins_pct;
    int noise_pct;
    cycles         = 0;
    sent           = 0;
    idle_on        = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = aidp_pkg::OP_INSERT;
    in_ch.position = '0;
    in_ch.value    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: errors on an empty list, inserts at front, middle and end with
    // extreme words, out-of-range positions, and deletes down to an empty list.
    send_item(aidp_pkg::OP_DELETE, 6'd1, 0);
    send_item(aidp_pkg::OP_DELETE, 6'd0, 0);
    send_item(aidp_pkg::OP_INSERT, 6'd0, 5);
    send_item(aidp_pkg::OP_INSERT, 6'd2, 5);
    send_item(aidp_pkg::OP_INSERT, 6'd1, 32'sh8000_0000);
    send_item(aidp_pkg::OP_INSERT, 6'd2, 32'sh7fff_ffff);
    send_item(aidp_pkg::OP_INSERT, 6'd1, -1);
    send_item(aidp_pkg::OP_INSERT, 6'd2, 0);
    send_item(aidp_pkg::OP_INSERT, 6'd63, 9);
    send_item(aidp_pkg::OP_DELETE, 6'd63, 0);
    send_item(aidp_pkg::OP_DELETE, 6'd5, 0);
    send_item(aidp_pkg::OP_DELETE, 6'd4, 0);
    send_item(aidp_pkg::OP_DELETE, 6'd1, 0);
    send_item(aidp_pkg::OP_DELETE, 6'd2, 0);
    send_item(aidp_pkg::OP_DELETE, 6'd1, 0);
    send_item(aidp_pkg::OP_INSERT, 6'd1, 32'sh5555_5555);
    send_item(aidp_pkg::OP_INSERT, 6'd1, 32'shaaaa_aaaa);
    send_item(aidp_pkg::OP_DELETE, 6'd2, 32'sh1234_5678);
    send_item(aidp_pkg::OP_DELETE, 6'd1, 0);

    // Random part in episodes: filling runs push toward the full list, draining runs
    // toward an empty one, and mixed or noisy runs fall in between. The last stretch
    // runs with both sides always ready.
    while (sent < ITEM_GOAL) begin
      ep_len    = $urandom_range(10, 50);
      noise_pct = 5;
      case ($urandom_range(0, 3))
        0: ins_pct = 90;
        1: ins_pct = 15;
        2: ins_pct = 55;
        default: begin
          ins_pct   = 50;
          noise_pct = 60;
        end
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (ep_len) begin
        if (sent >= ITEM_GOAL - 50) idle_on = 1'b0;
        if (sent < ITEM_GOAL) send_random(ins_pct, noise_pct);
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    idle_on     = 1'b0;

    // Wait for every pending result, then a little longer to catch any extra one.
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_count() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_count()));

    if (sb.errors == 0) begin
      $display("[array_insert_delete_at_position_unit] OK");
    end else begin
      $display("[array_insert_delete_at_position_unit] ERROR");
    end
    $finish;
  end

endmodule

/* array_insert_delete_at_position_unit.f */
design/aidp_pkg.sv
design/aidp_if.sv
design/aidp_ctrl.sv
design/aidp_dp.sv
design/array_insert_delete_at_position_unit.sv
verif/array_insert_delete_at_position_unit_tb.sv
